### rtl/imu_pkg.sv
`default_nettype none
package imu_pkg;
  localparam int unsigned DataWidthDef = 32;
  localparam int unsigned ResW = 64;
  localparam int unsigned CmdW = 4;

  typedef enum logic [3:0] {
    CmdAdd = 4'd0, CmdSub = 4'd1, CmdMul = 4'd2, CmdDiv = 4'd3,
    CmdLcm = 4'd4, CmdGcd = 4'd5, CmdPerm = 4'd6, CmdComb = 4'd7,
    CmdFact = 4'd8, CmdPow = 4'd9, CmdLog2 = 4'd10, CmdLogN = 4'd11
  } cmd_e;

  // Sequencer states.
  typedef enum logic [3:0] {
    StIdle, StCheck, StDivRun, StGcdRun, StLcmDiv, StLcmMul, StMulLoop,
    StCombDiv, StPowRun, StLogRun, StFinish, StDone
  } state_e;

  // Datapath operations requested by the sequencer.
  typedef enum logic [3:0] {
    OpNone, OpLoad, OpError, OpInit, OpDivStep, OpGcdStep, OpLcmDivStart,
    OpLcmMul, OpMulStep, OpCombStart, OpPowStep, OpLog2Step, OpLogNStep,
    OpFinish, OpEmit
  } op_e;

  typedef struct packed {
    op_e op;
  } ctrl_t;

  typedef struct packed {
    logic div_busy;
    logic gcd_done;
    logic mul_last;
    logic pow_last;
    logic log_last;
    logic dom_err;
  } stat_t;
endpackage
`default_nettype wire

### rtl/imu_if.sv
`default_nettype none
interface imu_in_if;
  logic        valid;
  logic        ready;
  logic [3:0]  cmd;
  logic signed [31:0] operand_a;
  logic signed [31:0] operand_b;
  modport source (output valid, cmd, operand_a, operand_b, input ready);
  modport sink (input valid, cmd, operand_a, operand_b, output ready);
endinterface

interface imu_out_if;
  logic        valid;
  logic        ready;
  logic signed [63:0] result;
  logic        error;
  modport source (output valid, result, error, input ready);
  modport sink (input valid, result, error, output ready);
endinterface
`default_nettype wire

### rtl/imu_ctrl.sv
`default_nettype none
module imu_ctrl import imu_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  in_valid_i,
  output logic       in_ready_o,
  input  wire logic [CmdW-1:0] cmd_i,
  output logic       out_valid_o,
  input  wire logic  out_ready_i,
  output ctrl_t      ctrl_o,
  input  wire stat_t stat_i
);
  state_e state_q, state_d;
  logic [CmdW-1:0] cmd_q;
  logic out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
      cmd_q       <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (in_valid_i && in_ready_o) cmd_q <= cmd_i;
    end
  end

  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q;
    ctrl_o.op   = OpNone;
    in_ready_o  = 1'b0;
    if (out_valid_q && out_ready_i) out_valid_d = 1'b0;
    unique case (state_q)
      StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          ctrl_o.op = OpLoad;
          state_d   = StCheck;
        end
      end
      StCheck: begin
        if (stat_i.dom_err) begin
          ctrl_o.op = OpError;
          state_d   = StDone;
        end else begin
          ctrl_o.op = OpInit;
          case (cmd_q) inside
            CmdDiv: state_d = StDivRun;
            CmdGcd, CmdLcm: state_d = StGcdRun;
            CmdPerm, CmdFact, CmdComb: state_d = StMulLoop;
            CmdPow: state_d = StPowRun;
            CmdLog2, CmdLogN: state_d = StLogRun;
            default: state_d = StFinish;
          endcase
        end
      end
      StDivRun: begin
        if (stat_i.div_busy) ctrl_o.op = OpDivStep;
        else state_d = StFinish;
      end
      StGcdRun: begin
        if (!stat_i.gcd_done) ctrl_o.op = OpGcdStep;
        else if (cmd_q == CmdLcm) begin
          ctrl_o.op = OpLcmDivStart; state_d = StLcmDiv;
        end else state_d = StFinish;
      end
      StLcmDiv: begin
        if (stat_i.div_busy) ctrl_o.op = OpDivStep;
        else state_d = StLcmMul;
      end
      StLcmMul: begin ctrl_o.op = OpLcmMul; state_d = StFinish; end
      StMulLoop: begin
        if (!stat_i.mul_last) ctrl_o.op = OpMulStep;
        else if (cmd_q == CmdComb) begin
          ctrl_o.op = OpCombStart; state_d = StCombDiv;
        end else state_d = StFinish;
      end
      StCombDiv: begin
        if (stat_i.div_busy) ctrl_o.op = OpDivStep;
        else state_d = StFinish;
      end
      StPowRun: begin
        if (!stat_i.pow_last) ctrl_o.op = OpPowStep;
        else state_d = StFinish;
      end
      StLogRun: begin
        if (!stat_i.log_last) begin
          ctrl_o.op = (cmd_q == CmdLog2) ? OpLog2Step : OpLogNStep;
        end else state_d = StFinish;
      end
      StFinish: begin ctrl_o.op = OpFinish; state_d = StDone; end
      StDone: begin
        // The output register takes the result only once the previous item has left.
        if (!out_valid_q || out_ready_i) begin
          ctrl_o.op   = OpEmit;
          out_valid_d = 1'b1;
          state_d     = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end
endmodule
`default_nettype wire

### rtl/imu_dp.sv
`default_nettype none
module imu_dp import imu_pkg::*; #(
  parameter int unsigned DataWidth = DataWidthDef
) (
  input  wire logic clk_i,
  input  wire logic [CmdW-1:0] cmd_i,
  input  wire logic [31:0] a_i,
  input  wire logic [31:0] b_i,
  input  wire ctrl_t ctrl_i,
  output stat_t      stat_o,
  output logic [ResW-1:0] result_o,
  output logic       error_o
);
  localparam int unsigned DW = DataWidth;
  localparam int unsigned PW = 2 * DW;
  localparam logic [63:0] SMax = (64'd1 << (DW - 1)) - 64'd1;

  logic [CmdW-1:0] cmd_q;
  logic signed [DW-1:0] a_q, b_q;
  // Shared restoring divider on unsigned 64-bit values.
  logic [63:0] dq_q, dr_q, dd_q;
  logic [6:0]  dcnt_q;
  logic        dneg_q;
  // Binary gcd registers; gk_q counts the common factors of two.
  logic [DW-1:0] ga_q, gb_q;
  logic [5:0]  gk_q;
  logic [63:0] acc_q, base_q, fct_q, res_q, out_res_q;
  logic [DW-1:0] exp_q;
  logic [5:0]  cnt_q;
  logic [5:0]  lim_q;
  logic        err_q, out_err_q;

  logic signed [63:0] sa, sb;
  assign sa = 64'(a_q);
  assign sb = 64'(b_q);

  function automatic logic [63:0] sext(input logic [63:0] v);
    logic [DW-1:0] t;
    t = v[DW-1:0];
    return 64'(signed'(t));
  endfunction

  logic [64:0] rem_try;
  logic [63:0] rem_sh;
  assign rem_sh  = {dr_q[62:0], dq_q[63]};
  assign rem_try = {1'b0, rem_sh} - {1'b0, dd_q};

  logic dom_err;
  always_comb begin
    case (cmd_q) inside
      CmdLcm, CmdGcd: dom_err = (sa < 1) || (sb < 1);
      CmdPerm, CmdComb: dom_err = (sb < 0) || (sb > sa) || (sa > 20);
      CmdFact: dom_err = (sa < 0) || (sa > 20);
      CmdLog2: dom_err = (sa < 1);
      CmdLogN: dom_err = (sa < 1) || (sb < 2);
      CmdAdd, CmdSub, CmdMul, CmdDiv, CmdPow: dom_err = 1'b0;
      default: dom_err = 1'b1;
    endcase
  end

  assign stat_o.dom_err  = dom_err;
  assign stat_o.div_busy = (dcnt_q != '0);
  assign stat_o.gcd_done = (ga_q == gb_q);
  assign stat_o.mul_last = (cnt_q >= lim_q);
  assign stat_o.pow_last = (exp_q == '0);
  // LogN counts the powers of the base that do not exceed the argument.
  assign stat_o.log_last = (cmd_q == CmdLog2) ? (acc_q <= 64'd1)
                         : (base_q > $unsigned(sa));

  logic [5:0] mulop;
  assign mulop = (cmd_q == CmdFact) ? cnt_q : (6'(sa) - cnt_q);

  // One general multiplier with selected operands and one squarer for power.
  logic [DW-1:0] mul_x, mul_y;
  always_comb begin
    case (cmd_q)
      CmdMul: begin mul_x = a_q; mul_y = b_q; end
      CmdLcm: begin mul_x = dq_q[DW-1:0]; mul_y = b_q; end
      CmdLogN: begin mul_x = base_q[DW-1:0]; mul_y = b_q; end
      default: begin mul_x = acc_q[DW-1:0]; mul_y = base_q[DW-1:0]; end
    endcase
  end

  logic [PW-1:0] prod_main, prod_sq;
  assign prod_main = PW'(mul_x) * PW'(mul_y);
  assign prod_sq   = PW'(base_q[DW-1:0]) * PW'(base_q[DW-1:0]);

  always_ff @(posedge clk_i) begin
    unique case (ctrl_i.op)
      OpLoad: begin
        cmd_q <= cmd_i;
        a_q <= a_i[DW-1:0];
        b_q <= b_i[DW-1:0];
        dcnt_q <= '0;
        err_q <= 1'b0;
      end
      OpError: begin err_q <= 1'b1; res_q <= '0; end
      OpInit: begin
        case (cmd_q) inside
          CmdDiv: begin
            // Divide magnitudes, fix sign at the end.
            dq_q <= sa[63] ? $unsigned(-sa) : $unsigned(sa);
            dd_q <= sb[63] ? $unsigned(-sb) : $unsigned(sb);
            dneg_q <= sa[63] ^ sb[63];
            dr_q <= '0;
            dcnt_q <= (sb == 0) ? 7'd0 : 7'd64;
          end
          CmdGcd, CmdLcm: begin
            ga_q <= a_q[DW-1:0];
            gb_q <= b_q[DW-1:0];
            gk_q <= '0;
          end
          CmdFact: begin cnt_q <= 6'd2; lim_q <= 6'(sa) + 6'd1; acc_q <= 64'd1; end
          CmdPerm, CmdComb: begin
            cnt_q <= '0; lim_q <= 6'(sb); acc_q <= 64'd1; fct_q <= 64'd1;
          end
          CmdPow: begin
            acc_q <= 64'd1; base_q <= 64'(a_q[DW-1:0]);
            exp_q <= (sb < 1) ? '0 : b_q[DW-1:0];
          end
          CmdLog2: begin acc_q <= $unsigned(sa); cnt_q <= '0; end
          CmdLogN: begin base_q <= $unsigned(sb); cnt_q <= '0; end
          default: ;
        endcase
      end
      OpDivStep: begin
        if (!rem_try[64]) begin
          dr_q <= rem_try[63:0];
          dq_q <= {dq_q[62:0], 1'b1};
        end else begin
          dr_q <= rem_sh;
          dq_q <= {dq_q[62:0], 1'b0};
        end
        dcnt_q <= dcnt_q - 7'd1;
      end
      OpGcdStep: begin
        if (!ga_q[0] && !gb_q[0]) begin
          ga_q <= ga_q >> 1;
          gb_q <= gb_q >> 1;
          gk_q <= gk_q + 6'd1;
        end else if (!ga_q[0]) ga_q <= ga_q >> 1;
        else if (!gb_q[0]) gb_q <= gb_q >> 1;
        else if (ga_q > gb_q) ga_q <= (ga_q - gb_q) >> 1;
        else gb_q <= (gb_q - ga_q) >> 1;
      end
      OpLcmDivStart: begin
        dq_q <= $unsigned(sa); dd_q <= 64'(ga_q) << gk_q; dr_q <= '0;
        dneg_q <= 1'b0; dcnt_q <= 7'd64;
      end
      OpLcmMul: acc_q <= 64'(prod_main);
      OpMulStep: begin
        acc_q <= acc_q * {58'd0, mulop};
        fct_q <= fct_q * {58'd0, cnt_q + 6'd1};
        cnt_q <= cnt_q + 6'd1;
      end
      OpCombStart: begin
        dq_q <= acc_q; dd_q <= fct_q; dr_q <= '0; dneg_q <= 1'b0; dcnt_q <= 7'd64;
      end
      OpPowStep: begin
        if (exp_q[0]) acc_q <= 64'(prod_main[DW-1:0]);
        base_q <= 64'(prod_sq[DW-1:0]);
        exp_q <= exp_q >> 1;
      end
      OpLog2Step: begin
        acc_q <= acc_q >> 1;
        cnt_q <= cnt_q + 6'd1;
      end
      OpLogNStep: begin
        base_q <= 64'(prod_main);
        cnt_q <= cnt_q + 6'd1;
      end
      OpFinish: begin
        case (cmd_q) inside
          CmdAdd: res_q <= sext(64'(sa + sb));
          CmdSub: res_q <= sext(64'(sa - sb));
          CmdMul: res_q <= sext(64'(prod_main));
          CmdDiv: res_q <= (sb == 0) ? '0 : sext(dneg_q ? (64'd0 - dq_q) : dq_q);
          CmdGcd: res_q <= 64'(ga_q) << gk_q;
          CmdLcm: begin
            if (acc_q > SMax) begin err_q <= 1'b1; res_q <= '0; end
            else res_q <= acc_q;
          end
          CmdPerm, CmdFact: res_q <= acc_q;
          CmdComb: res_q <= dq_q;
          CmdPow: res_q <= sext(acc_q);
          CmdLog2, CmdLogN: res_q <= 64'(cnt_q);
          default: begin res_q <= '0; err_q <= 1'b1; end
        endcase
      end
      OpEmit: begin
        out_res_q <= res_q;
        out_err_q <= err_q;
      end
      default: ;
    endcase
  end

  assign result_o = out_res_q;
  assign error_o  = out_err_q;
endmodule
`default_nettype wire

### rtl/integer_math_unit_top.sv
// Path from the accepting edge to output valid: an out-of-domain item goes straight to done,
// add, sub and mul go straight to the finish state, and divide, gcd, lcm, nPr, nCr,
// factorial, power, log2 and logN first run their loop steps.
// Throughput: one item at a time; the next item is taken the cycle after the result is
// registered, and a result still waiting at the output holds the sequencer.
// Reset: rst_ni clears the sequencer and the output valid flag asynchronously.
`default_nettype none
module integer_math_unit_top import imu_pkg::*; #(
  parameter int unsigned DataWidth = DataWidthDef
) (
  input wire logic clk_i,
  input wire logic rst_ni,
  imu_in_if.sink   in_i,
  imu_out_if.source out_o
);
  ctrl_t ctrl;
  stat_t stat;

  imu_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i(in_i.valid), .in_ready_o(in_i.ready), .cmd_i(in_i.cmd),
    .out_valid_o(out_o.valid), .out_ready_i(out_o.ready),
    .ctrl_o(ctrl), .stat_i(stat)
  );

  imu_dp #(.DataWidth(DataWidth)) u_dp (
    .clk_i, .cmd_i(in_i.cmd), .a_i(in_i.operand_a), .b_i(in_i.operand_b),
    .ctrl_i(ctrl), .stat_o(stat), .result_o(out_o.result), .error_o(out_o.error)
  );
endmodule
`default_nettype wire

### rtl/imu_checker.sv
`default_nettype none
module imu_checker (
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic in_valid,
  input wire logic in_ready,
  input wire logic out_valid,
  input wire logic out_ready,
  input wire logic out_error,
  input wire logic [63:0] out_result
);
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && out_error |-> out_result == 64'd0) else $error("error with result");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(out_result)) else $error("drop");
  a_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid && in_ready |=> !in_ready) else $error("overlap");
endmodule

bind integer_math_unit_top imu_checker u_chk (
  .clk_i, .rst_ni, .in_valid(in_i.valid), .in_ready(in_i.ready),
  .out_valid(out_o.valid), .out_ready(out_o.ready),
  .out_error(out_o.error), .out_result(out_o.result)
);
`default_nettype wire
